FILE: hw/rtl/dfam_pkg.sv
// ----------------------------------------------------------------------------
// dfam_pkg
// Shared types, constants and the sine table generator for the modulator.
// ----------------------------------------------------------------------------
package dfam_pkg;

  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 32;
  localparam int unsigned QueueDepth = 4;

  localparam int unsigned RomBits = 15;
  localparam int unsigned FullScale = 32767;
  localparam int unsigned FmRound = 16383;
  localparam int unsigned AmRound = 1073709056;
  localparam int unsigned HalfPiQ30 = 1686629713;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgBaseIncrement  = 2'd0,
    CfgAmplitudeScale = 2'd1,
    CfgMode           = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ModeFm = 1'b0,
    ModeAm = 1'b1
  } mode_e;

  // rounded quarter-wave entry, sine by a q30 series up to x^15
  function automatic logic [RomBits-1:0] sine_entry(input int unsigned k,
                                                    input int unsigned addr_bits);
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    x = (64'(k) * 64'(HalfPiQ30)) >> addr_bits;
    term = x;
    sum = signed'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      case (n)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        6: term = term / 64'd156;
        7: term = term / 64'd210;
        default: term = term;
      endcase
      if (n % 2 == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    mag = (unsigned'(sum) * 64'(FullScale) + 64'd536870912) >> 30;
    return mag[RomBits-1:0];
  endfunction

endpackage

FILE: hw/rtl/dfam_if.sv
// ----------------------------------------------------------------------------
// dfam channel interfaces
// Sample tick requests, result samples and configuration writes.
// ----------------------------------------------------------------------------
interface dfam_in_if;
  logic               valid;
  logic               ready;
  logic               restart;
  logic signed [23:0] freq_offset;
  logic [15:0]        level;

  modport source (output valid, restart, freq_offset, level, input ready);
  modport sink (input valid, restart, freq_offset, level, output ready);
endinterface

interface dfam_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

interface dfam_cfg_if
  import dfam_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CfgIdxBits-1:0]  index;
  logic [CfgDataBits-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/dfam_queue.sv
// ----------------------------------------------------------------------------
// dfam_queue
// Small register queue between the phase front end and the output pipeline.
// ----------------------------------------------------------------------------
module dfam_queue
  import dfam_pkg::*;
#(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (count_q == CntBits'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hw/rtl/dfam_front.sv
// ----------------------------------------------------------------------------
// dfam_front
// Phase accumulator: takes sample ticks, folds the phase to a table index
// and quadrant sign, and advances the phase by the base step plus, in FM mode, the offset.
// ----------------------------------------------------------------------------
module dfam_front
  import dfam_pkg::*;
#(
  parameter int unsigned SineAddrBits = 10,
  parameter int unsigned PhaseBits    = 32,
  parameter int unsigned EntryBits    = SineAddrBits + 19
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dfam_in_if.sink              in_ch,
  input  logic [31:0]          base_increment_i,
  input  mode_e                mode_i,
  output logic                 push_o,
  output logic [EntryBits-1:0] entry_o,
  input  logic                 full_i
);

  logic [PhaseBits-1:0]    phase_q, phase_d;
  logic [PhaseBits-1:0]    phase_cur;
  logic [1:0]              quadrant;
  logic [SineAddrBits-1:0] addr;
  logic [SineAddrBits:0]   rom_idx;
  logic [63:0]             step;

  assign in_ch.ready = !full_i;
  assign push_o      = in_ch.valid && !full_i;

  assign phase_cur = in_ch.restart ? '0 : phase_q;
  assign quadrant  = phase_cur[PhaseBits-1 -: 2];
  assign addr      = phase_cur[PhaseBits-3 -: SineAddrBits];

  // odd quadrants read the table mirrored
  assign rom_idx = quadrant[0] ? ((SineAddrBits+1)'(1) << SineAddrBits) - {1'b0, addr}
                               : {1'b0, addr};

  always_comb begin
    step = {32'd0, base_increment_i};
    if (mode_i == ModeFm) begin
      step = step + {{40{in_ch.freq_offset[23]}}, in_ch.freq_offset};
    end
    phase_d = phase_cur + step[PhaseBits-1:0];
  end

  assign entry_o = {quadrant[1], rom_idx, mode_i, in_ch.level};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
    end
  end

endmodule

FILE: hw/rtl/dfam_back.sv
// ----------------------------------------------------------------------------
// dfam_back
// Output pipeline: sine table read, amplitude and (in AM mode) level scaling, rounding
// division by full scale, sign and output register.
// ----------------------------------------------------------------------------
module dfam_back
  import dfam_pkg::*;
#(
  parameter int unsigned SineAddrBits = 10,
  parameter int unsigned EntryBits    = SineAddrBits + 19
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [EntryBits-1:0] entry_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  input  logic [14:0]          amplitude_scale_i,
  dfam_out_if.source           out_ch
);

  localparam int unsigned RomLen = (1 << SineAddrBits) + 1;

  logic [RomBits-1:0] sine_rom [RomLen];

  for (genvar k = 0; k < RomLen; k++) begin : g_rom
    localparam logic [RomBits-1:0] Entry = sine_entry(k, SineAddrBits);
    assign sine_rom[k] = Entry;
  end

  logic                  e_neg;
  logic [SineAddrBits:0] e_idx;
  logic                  e_mode;
  logic [15:0]           e_level;

  assign {e_neg, e_idx, e_mode, e_level} = entry_i;

  logic        adv;
  logic [4:0]  vld_q;

  logic [14:0] r_q;
  logic        neg1_q, neg2_q, neg3_q, neg4_q;
  mode_e       mode1_q, mode2_q;
  logic [15:0] lvl1_q, lvl2_q;
  logic [29:0] ra_q;
  logic [29:0] y_q, y4_q;
  logic [15:0] q0_q;
  logic signed [15:0] sample_q;

  logic [46:0] am_sum;
  logic [29:0] y_d;
  logic [30:0] s_sum;
  logic [31:0] q0_mul;
  logic [31:0] rem;
  logic [15:0] mag;

  assign adv   = !vld_q[4] || out_ch.ready;
  assign pop_o = adv && !empty_i;

  assign out_ch.valid  = vld_q[4];
  assign out_ch.sample = sample_q;

  // level scaling, then the low 16 bits go with the rounding
  assign am_sum = 47'(ra_q) * 47'(lvl2_q) + 47'(AmRound);
  assign y_d    = (mode2_q == ModeAm) ? am_sum[45:16] : ra_q + 30'(FmRound);

  // divide by 2^15 - 1: reciprocal series, then one correction
  assign s_sum  = 31'(y_q) + 31'(y_q >> 15) + 31'(y_q >> 30);
  assign q0_mul = {1'b0, q0_q, 15'd0} - 32'(q0_q);
  assign rem    = 32'(y4_q) - q0_mul;
  assign mag    = (rem >= 32'(FullScale)) ? q0_q + 16'd1 : q0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[3:0], !empty_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q      <= sine_rom[e_idx];
      neg1_q   <= e_neg;
      mode1_q  <= mode_e'(e_mode);
      lvl1_q   <= e_level;
      ra_q     <= 30'(r_q) * 30'(amplitude_scale_i);
      neg2_q   <= neg1_q;
      mode2_q  <= mode1_q;
      lvl2_q   <= lvl1_q;
      y_q      <= y_d;
      neg3_q   <= neg2_q;
      q0_q     <= s_sum[30:15];
      y4_q     <= y_q;
      neg4_q   <= neg3_q;
      sample_q <= neg4_q ? -signed'(mag) : signed'(mag);
    end
  end

endmodule

FILE: hw/rtl/dds_fm_am_modulator_core.sv
// ----------------------------------------------------------------------------
// dds_fm_am_modulator_core
// Sine oscillator with frequency or amplitude modulation.
//
// in_ch carries one request per sample tick (restart, freq_offset, level);
// out_ch returns one sample per request, in order. cfg_ch writes
// base_increment, amplitude_scale and mode; it is always ready and the user
// writes it only while no request is in flight; the block does not enforce it.
// A request is taken every cycle while the four-entry queue between the
// phase front end and the output pipeline has room. The front end updates
// the phase in the cycle of acceptance; the output pipeline (table read,
// two multiplies, a two-step divide by full scale, output register) shows
// the sample once its entry has passed the queue and each of these stages.
// When the receiver stalls, the output pipeline holds, the queue fills,
// and then in_ch.ready drops. Reset clears the phase, mode and increment,
// sets amplitude_scale to full scale and empties the pipeline.
// ----------------------------------------------------------------------------
module dds_fm_am_modulator_core
  import dfam_pkg::*;
#(
  parameter int unsigned SINE_ADDR_BITS = 10,
  parameter int unsigned PHASE_BITS     = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dfam_cfg_if.sink   cfg_ch,
  dfam_in_if.sink    in_ch,
  dfam_out_if.source out_ch
);

  localparam int unsigned EntryBits = SINE_ADDR_BITS + 19;

  logic [31:0] base_increment_q;
  logic [14:0] amplitude_scale_q;
  mode_e       mode_q;

  logic                 push;
  logic                 pop;
  logic                 full;
  logic                 empty;
  logic [EntryBits-1:0] entry_in;
  logic [EntryBits-1:0] entry_out;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_increment_q  <= '0;
      amplitude_scale_q <= 15'(FullScale);
      mode_q            <= ModeFm;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_e'(cfg_ch.index))
        CfgBaseIncrement:  base_increment_q  <= cfg_ch.data;
        CfgAmplitudeScale: amplitude_scale_q <= cfg_ch.data[14:0];
        CfgMode:           mode_q            <= mode_e'(cfg_ch.data[0]);
        default: ;
      endcase
    end
  end

  dfam_front #(
    .SineAddrBits (SINE_ADDR_BITS),
    .PhaseBits    (PHASE_BITS),
    .EntryBits    (EntryBits)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_ch            (in_ch),
    .base_increment_i (base_increment_q),
    .mode_i           (mode_q),
    .push_o           (push),
    .entry_o          (entry_in),
    .full_i           (full)
  );

  dfam_queue #(
    .Width (EntryBits),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (entry_out),
    .empty_o (empty)
  );

  dfam_back #(
    .SineAddrBits (SINE_ADDR_BITS),
    .EntryBits    (EntryBits)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .entry_i           (entry_out),
    .empty_i           (empty),
    .pop_o             (pop),
    .amplitude_scale_i (amplitude_scale_q),
    .out_ch            (out_ch)
  );

endmodule

FILE: test/dds_fm_am_modulator_core_test.sv
// ----------------------------------------------------------------------------
// dds_fm_am_modulator_core_test
// Drives sample tick requests through bursts and gaps while the receiver
// stalls, predicts every sample from a local phase accumulator and quarter
// sine table, and checks results in order across register settings.
// ----------------------------------------------------------------------------
module dds_fm_am_modulator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dfam_pkg::*;

  localparam int unsigned ClkPeriod     = 20;
  localparam int unsigned SineAddrBits  = 10;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned DrainCycles   = 12;
  localparam logic [63:0] QuarterTurnQ30 = 64'd1686629713;
  localparam logic [63:0] AmDen         = 64'd32767 << 16;
  localparam logic [63:0] AmHalf        = 64'd1073709056;
  localparam logic [1:0]  CfgSpare      = 2'd3;

  typedef struct packed {
    logic               restart;
    logic signed [23:0] freq_offset;
    logic [15:0]        level;
  } tick_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dfam_cfg_if cfg_ch ();
  dfam_in_if  in_ch ();
  dfam_out_if out_ch ();

  dds_fm_am_modulator_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // local copy of the oscillator state and registers
  logic [14:0] sine_tab [0:(1 << SineAddrBits)];
  logic [31:0] phase_acc;
  logic [31:0] base_inc;
  logic [14:0] amp_scale;
  mode_e       cur_mode;

  tick_t              tick_q [$];
  logic signed [15:0] sample_q [$];
  int unsigned        errors = 0;
  int unsigned        cycles = 0;
  logic               tick_taken = 1'b0;
  int unsigned        burst_left = 0;
  int unsigned        gap_left = 0;
  logic [15:0]        stall_mask = 16'hffff;
  int unsigned        stall_pos = 0;

  function automatic logic [14:0] quarter_sine(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        t;
    logic [63:0]        s;
    logic signed [63:0] acc;
    x = (64'(k) * QuarterTurnQ30) >> SineAddrBits;
    t = x;
    acc = signed'(x);
    for (int n = 1; n <= 7; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - signed'(t);
      end else begin
        acc = acc + signed'(t);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > 64'sd1073741824) begin
      acc = 64'sd1073741824;
    end
    s = (unsigned'(acc) * 64'd32767 + 64'd536870912) >> 30;
    return s[14:0];
  endfunction

  // sample for one tick, then advance the phase
  function automatic logic signed [15:0] next_sample(input logic restart,
                                                     input logic signed [23:0] offset,
                                                     input logic [15:0] level);
    logic [1:0]  quad;
    logic [10:0] idx;
    logic [63:0] mag;
    logic [15:0] m;
    logic [31:0] step;
    if (restart) begin
      phase_acc = '0;
    end
    quad = phase_acc[31:30];
    idx = {1'b0, phase_acc[29:20]};
    if (quad[0]) begin
      idx = 11'd1024 - idx;
    end
    if (cur_mode == ModeAm) begin
      mag = (64'(sine_tab[idx]) * 64'(amp_scale) * 64'(level) + AmHalf) / AmDen;
    end else begin
      mag = (64'(sine_tab[idx]) * 64'(amp_scale) + 64'd16383) / 64'd32767;
    end
    m = mag[15:0];
    step = base_inc;
    if (cur_mode == ModeFm) begin
      step = step + {{8{offset[23]}}, offset};
    end
    phase_acc = phase_acc + step;
    return quad[1] ? -m : m;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CfgBaseIncrement:  base_inc = data;
      CfgAmplitudeScale: amp_scale = data[14:0];
      CfgMode:           cur_mode = mode_e'(data[0]);
      default:           ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic queue_tick(input logic restart, input logic signed [23:0] offset,
                            input logic [15:0] level);
    tick_t t;
    t.restart = restart;
    t.freq_offset = offset;
    t.level = level;
    tick_q.insert(tick_q.size(), t);
  endtask

  task automatic wait_idle();
    while (tick_q.size() != 0 || in_ch.valid || sample_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_settings();
    logic [31:0] base;
    logic [14:0] amp;
    base = $urandom();
    case ($urandom_range(0, 4))
      0: base = '0;
      1: base = '1;
      2: base = $urandom_range(0, 1 << 22);
      default: ;
    endcase
    amp = 15'($urandom_range(0, 32767));
    case ($urandom_range(0, 3))
      0: amp = '0;
      1: amp = 15'd32767;
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) begin
      write_reg(CfgSpare, $urandom());
    end
    write_reg(CfgBaseIncrement, base);
    write_reg(CfgAmplitudeScale, {17'($urandom_range(0, 131071)), amp});
    write_reg(CfgMode, {16'($urandom_range(0, 65535)), 15'($urandom()), 1'($urandom())});
  endtask

  task automatic random_ticks(input int unsigned count);
    logic signed [23:0] offset;
    logic [15:0]        level;
    for (int i = 0; i < count; i++) begin
      offset = 24'($urandom());
      case ($urandom_range(0, 7))
        0: offset = 24'sh800000;
        1: offset = 24'sh7fffff;
        2: offset = 24'($urandom_range(0, 64)) - 24'sd32;
        default: ;
      endcase
      level = 16'($urandom());
      case ($urandom_range(0, 7))
        0: level = '0;
        1: level = '1;
        default: ;
      endcase
      queue_tick($urandom_range(0, 31) == 0, offset, level);
    end
  endtask

  // request sender: bursts with random gaps, valid held until taken
  always @(negedge clk_i) begin
    tick_t t;
    if (rst_ni) begin
      if (!in_ch.valid || tick_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          t = tick_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.restart <= t.restart;
          in_ch.freq_offset <= t.freq_offset;
          in_ch.level <= t.level;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_pos == 0) begin
        case ($urandom_range(0, 3))
          0: stall_mask = '1;
          1: stall_mask = 16'($urandom() & $urandom()) | 16'h0001;
          default: stall_mask = 16'($urandom()) | 16'h0001;
        endcase
      end
      out_ch.ready <= stall_mask[stall_pos];
      stall_pos = (stall_pos + 1) % 16;
    end
  end

  // prediction on accepted requests, in-order check of samples
  always @(posedge clk_i) begin
    logic signed [15:0] want;
    tick_taken = in_ch.valid && in_ch.ready;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        sample_q.insert(sample_q.size(),
                        next_sample(in_ch.restart, in_ch.freq_offset, in_ch.level));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (sample_q.size() == 0) begin
          $error("sample: expected none, actual %0d", out_ch.sample);
          errors++;
        end else begin
          want = sample_q.pop_front();
          if (out_ch.sample !== want) begin
            $error("sample: expected %0d, actual %0d", want, out_ch.sample);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** dds_fm_am_modulator_core: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k <= (1 << SineAddrBits); k++) begin
      sine_tab[k] = quarter_sine(k);
    end
    phase_acc = '0;
    base_inc = '0;
    amp_scale = 15'd32767;
    cur_mode = ModeFm;
    rst_ni = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.restart = 1'b0;
    in_ch.freq_offset = '0;
    in_ch.level = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // settings after reset
    queue_tick(1'b1, 24'sd0, 16'd0);
    queue_tick(1'b0, 24'sd4194304, 16'd0);
    queue_tick(1'b0, 24'sh800000, 16'hffff);
    queue_tick(1'b0, 24'sd0, 16'd0);
    wait_idle();

    // quarter-turn steps hit the quadrant edges, then extreme offsets
    write_reg(CfgBaseIncrement, 32'h4000_0000);
    write_reg(CfgAmplitudeScale, 32'hffff_ffff);
    write_reg(CfgMode, 32'hffff_fffe);
    queue_tick(1'b1, 24'sd0, 16'hffff);
    repeat (4) queue_tick(1'b0, 24'sd0, 16'd0);
    queue_tick(1'b0, 24'sh7fffff, 16'd0);
    queue_tick(1'b0, 24'sh800000, 16'd0);
    queue_tick(1'b0, 24'sd0, 16'd0);
    wait_idle();

    // amplitude mode, extreme levels, offsets ignored
    write_reg(CfgSpare, 32'hdead_beef);
    write_reg(CfgMode, 32'd1);
    queue_tick(1'b1, 24'sh7fffff, 16'hffff);
    queue_tick(1'b0, 24'sh800000, 16'hffff);
    queue_tick(1'b0, 24'sh7fffff, 16'd0);
    queue_tick(1'b0, 24'sd0, 16'h8000);
    queue_tick(1'b0, 24'sd1, 16'd1);
    wait_idle();

    // full-scale step runs the phase backwards unless the offset is positive, zero amplitude
    write_reg(CfgBaseIncrement, 32'hffff_ffff);
    write_reg(CfgAmplitudeScale, 32'hffff_8000);
    write_reg(CfgMode, 32'd0);
    queue_tick(1'b1, 24'sh800000, 16'd0);
    queue_tick(1'b0, 24'sh7fffff, 16'hffff);
    queue_tick(1'b0, 24'sd0, 16'd0);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      random_settings();
      random_ticks(150);
      wait_idle();
    end

    if (errors == 0) begin
      $display("** dds_fm_am_modulator_core: PASSED **");
    end else begin
      $display("** dds_fm_am_modulator_core: FAILED **");
    end
    $finish;
  end

endmodule
